// ===== rtl/swo_mp_pkg.sv =====
`timescale 1ns / 1ps

package swo_mp_pkg;

    localparam logic [7:0] START_BYTE = 8'h02;
    localparam logic [7:0] SPACE_BYTE = 8'h00;

    localparam logic [1:0] SIZE_ONE  = 2'd1;
    localparam logic [1:0] SIZE_TWO  = 2'd2;
    localparam logic [1:0] SIZE_FOUR = 2'd3;

    // What a job expands into on the back side.
    typedef enum logic [2:0] {
        MODE_FULL,      // four-byte packet, no space byte
        MODE_FULL_SP,   // four-byte packet, message ends here
        MODE_END1,      // one-byte packet with space
        MODE_END2,      // two-byte packet with space
        MODE_END3       // two-byte packet, then one-byte packet with space
    } job_mode_t;

    typedef struct packed {
        logic [4:0]      channel;
        logic [3:0][7:0] data;    // data[0] goes out first
        job_mode_t       mode;
    } job_t;

    typedef enum logic {
        BK_IDLE,
        BK_RUN
    } back_state_t;

    // Bit i of the nibble becomes pair {b, ~b} at bits 7-2i..6-2i.
    function automatic logic [7:0] manch_nibble(input logic [3:0] nib);
        logic [7:0] r;
        r = '0;
        for (int i = 0; i < 4; i++)
        begin
            r[7 - 2 * i] = nib[i];
            r[6 - 2 * i] = ~nib[i];
        end
        return r;
    endfunction

endpackage

// ===== rtl/swo_mp_front.sv =====
`timescale 1ns / 1ps

module swo_mp_front
    import swo_mp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,
    input  logic        in_fire,
    input  logic [7:0]  payload_byte,
    input  logic [4:0]  trace_channel,
    input  logic        message_end,
    output logic        push,
    output job_t        push_job
);

    logic [31:0] mask_reg;
    logic [7:0]  pending_reg [3];
    logic [1:0]  count_reg;
    logic [1:0]  count_next;
    logic [2:0]  cnt;
    logic        enabled;
    logic        store;

    assign enabled = mask_reg[trace_channel];
    assign cnt     = {1'b0, count_reg} + 3'd1;

    always_comb
    begin
        push_job.channel = trace_channel;
        for (int i = 0; i < 3; i++)
        begin
            if (2'(i) < count_reg)
                push_job.data[i] = pending_reg[i];
            else
                push_job.data[i] = payload_byte;
        end
        push_job.data[3] = payload_byte;
        priority if (cnt == 3'd4)
            push_job.mode = message_end ? MODE_FULL_SP : MODE_FULL;
        else if (cnt == 3'd3)
            push_job.mode = MODE_END3;
        else if (cnt == 3'd2)
            push_job.mode = MODE_END2;
        else
            push_job.mode = MODE_END1;
    end

    assign push  = in_fire && enabled && (cnt == 3'd4 || message_end);
    assign store = in_fire && enabled && !(cnt == 3'd4 || message_end);

    always_comb
    begin
        count_next = count_reg;
        if (in_fire)
        begin
            if (store)
                count_next = cnt[1:0];
            else if (push || message_end)
                count_next = 2'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (cfg_we)
                mask_reg <= cfg_wdata;
            count_reg <= count_next;
        end
    end

    // held bytes: written before read, no reset
    always_ff @(posedge clk)
    begin
        if (store)
            pending_reg[count_reg] <= payload_byte;
    end

endmodule

// ===== rtl/swo_mp_queue.sv =====
`timescale 1ns / 1ps

module swo_mp_queue
    import swo_mp_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    input  logic pop,
    output logic full,
    output logic head_valid,
    output job_t head_job
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    job_t          entry_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg;
    logic [AW-1:0] rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic          do_push;
    logic          do_pop;

    assign full       = (count_reg == CW'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_job   = entry_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_job;
    end

endmodule

// ===== rtl/swo_mp_back.sv =====
`timescale 1ns / 1ps

module swo_mp_back
    import swo_mp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       head_valid,
    input  job_t       head_job,
    output logic       pop,
    output logic       busy,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] spi_byte,
    output logic       transfer_end,
    output logic       run_last
);

    back_state_t state_reg, state_next;
    job_t        job_reg;
    logic [3:0]  step_reg;
    logic        phase_reg;

    logic        out_valid_reg;
    logic [7:0]  byte_reg;
    logic        tend_reg;
    logic        rlast_reg;

    // current packet shape
    logic [2:0]  n_bytes;
    logic [1:0]  size_code;
    logic        with_space;
    logic [1:0]  offset;
    logic        job_final;
    logic [3:0]  last_step;

    logic        emit;
    logic        pkt_end;
    logic        at_end;
    logic [3:0]  dstep;
    logic [1:0]  didx;
    logic [7:0]  src_byte;
    logic [3:0]  nib;
    logic [7:0]  byte_next;

    always_comb
    begin
        n_bytes    = 3'd1;
        size_code  = SIZE_ONE;
        with_space = 1'b1;
        offset     = 2'd0;
        job_final  = 1'b1;
        unique case (job_reg.mode)
            MODE_FULL:
            begin
                n_bytes    = 3'd4;
                size_code  = SIZE_FOUR;
                with_space = 1'b0;
            end
            MODE_FULL_SP:
            begin
                n_bytes   = 3'd4;
                size_code = SIZE_FOUR;
            end
            MODE_END1: ;
            MODE_END2:
            begin
                n_bytes   = 3'd2;
                size_code = SIZE_TWO;
            end
            MODE_END3:
            begin
                if (phase_reg)
                    offset = 2'd2;
                else
                begin
                    n_bytes    = 3'd2;
                    size_code  = SIZE_TWO;
                    with_space = 1'b0;
                    job_final  = 1'b0;
                end
            end
            default: ;
        endcase
    end

    // start, two header halves, two halves per data byte, optional space
    assign last_step = 4'd2 + {n_bytes, 1'b0} + {3'd0, with_space};

    assign dstep    = step_reg - 4'd3;
    assign didx     = dstep[2:1] + offset;
    assign src_byte = (step_reg < 4'd3) ? {job_reg.channel, 1'b0, size_code}
                                        : job_reg.data[didx];
    assign nib      = step_reg[0] ? src_byte[3:0] : src_byte[7:4];

    always_comb
    begin
        priority if (step_reg == '0)
            byte_next = START_BYTE;
        else if (with_space && step_reg == last_step)
            byte_next = SPACE_BYTE;
        else
            byte_next = manch_nibble(nib);
    end

    assign pkt_end = (step_reg == last_step);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
                if (head_valid)
                    state_next = BK_RUN;
            BK_RUN:
                if (at_end && !head_valid)
                    state_next = BK_IDLE;
            default:
                state_next = BK_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        emit = 1'b0;
        pop  = 1'b0;
        unique case (state_reg)
            BK_IDLE:
                pop = head_valid;
            BK_RUN:
            begin
                emit = !out_valid_reg || out_ready;
                pop  = emit && pkt_end && job_final && head_valid;
            end
            default: ;
        endcase
    end

    assign at_end = emit && pkt_end && job_final;
    assign busy   = (state_reg == BK_RUN);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
            step_reg      <= '0;
            phase_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (emit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            if (pop)
            begin
                step_reg  <= '0;
                phase_reg <= 1'b0;
            end
            else if (emit)
            begin
                if (pkt_end)
                begin
                    step_reg  <= '0;
                    phase_reg <= 1'b1;
                end
                else
                    step_reg <= step_reg + 4'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            job_reg <= head_job;
        if (emit)
        begin
            byte_reg  <= byte_next;
            tend_reg  <= pkt_end;
            rlast_reg <= pkt_end && job_final;
        end
    end

    assign out_valid    = out_valid_reg;
    assign spi_byte     = byte_reg;
    assign transfer_end = tend_reg;
    assign run_last     = rlast_reg;

endmodule

// ===== rtl/swo_manchester_packetizer.sv =====
`timescale 1ns / 1ps

// channel   dir  transaction payload
// s_*       in   tdata = payload_byte, trace_channel; tlast = message_end
// m_*       out  tdata = spi_byte; tuser = transfer_end; tlast = run_last
// cfg_*     in   channel_enable_mask, one write per cycle with cfg_we high
//
// The front takes one byte per cycle while the job queue has room; the back
// emits one SPI byte per cycle while running and m_tready is high; an item
// yields 0 to 13 SPI bytes, so the back's byte sequencer sets the rate.
// Reset clears the mask, held-byte count, queue and output stage; no
// clearing pass. m_tready low stalls only the back; the front keeps taking
// bytes until the queue fills.

module swo_manchester_packetizer
    import swo_mp_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,      // channel_enable_mask
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,        // [7:0] payload_byte, [12:8] trace_channel, rest 0
    input  logic        s_tlast,        // message_end
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,        // [7:0] spi_byte
    output logic        m_tuser,        // [0] transfer_end
    output logic        m_tlast         // run_last
);

    logic in_fire;
    logic q_push;
    job_t q_push_job;
    logic q_full;
    logic q_valid;
    job_t q_head;
    logic q_pop;
    logic back_busy;

    // a full queue holds off the slave side; the back drains it
    assign s_tready = !q_full;
    assign in_fire  = s_tvalid && s_tready;

    swo_mp_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .in_fire       (in_fire),
        .payload_byte  (s_tdata[7:0]),
        .trace_channel (s_tdata[12:8]),
        .message_end   (s_tlast),
        .push          (q_push),
        .push_job      (q_push_job)
    );

    swo_mp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_job   (q_push_job),
        .pop        (q_pop),
        .full       (q_full),
        .head_valid (q_valid),
        .head_job   (q_head)
    );

    swo_mp_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (q_valid),
        .head_job     (q_head),
        .pop          (q_pop),
        .busy         (back_busy),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .spi_byte     (m_tdata),
        .transfer_end (m_tuser),
        .run_last     (m_tlast)
    );

    // the end of a job always closes a packet transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> m_tuser)
        else $error("run end without transfer end");

    // the front never pushes into a full queue
    assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("job queue overflow");

    // an idle back picks up a waiting job on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        q_valid && !back_busy |=> back_busy)
        else $error("waiting job not started");

    // a new job is only taken at the end of the current one or from idle
    assert property (@(posedge clk) disable iff (!rst_n)
        q_pop && back_busy |=> m_tvalid && m_tlast)
        else $error("job taken before current job finished");

endmodule
